### hw/rtl/srk_pkg.sv
package srk_pkg;

   localparam int DEFAULT_MAX_N = 256;

   localparam int SIZE_W      = 9;
   localparam int VALUE_W     = 32;
   localparam int INDEX_W     = 8;
   localparam int VEC_W       = 2 * VALUE_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATRIX_SIZE = 2'd0,
      CSR_UPPER_FILL  = 2'd1,
      CSR_ALPHA_SCALE = 2'd2
   } csr_index_type;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_MATRIX = 1'b1;

   localparam logic [SIZE_W-1:0]         RESET_MATRIX_SIZE = 9'd1;
   localparam logic                      RESET_UPPER_FILL  = 1'b1;
   localparam logic signed [VALUE_W-1:0] RESET_ALPHA_SCALE = 32'sd65536;

   typedef struct packed {
      logic                      mode;
      logic signed [VALUE_W-1:0] x_value;
      logic signed [VALUE_W-1:0] y_value;
      logic signed [VALUE_W-1:0] a_value;
   } req_word_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] updated_value;
      logic [INDEX_W-1:0]        row_index;
      logic [INDEX_W-1:0]        col_index;
      logic                      last_element;
   } rsp_word_type;

   typedef struct packed {
      logic [SIZE_W-1:0]         matrix_size;
      logic                      upper_fill;
      logic signed [VALUE_W-1:0] alpha_scale;
   } cfg_type;

   // Everything about one matrix element that travels beside the arithmetic.
   typedef struct packed {
      logic                      in_triangle;
      logic                      last;
      logic [INDEX_W-1:0]        row;
      logic [INDEX_W-1:0]        col;
      logic signed [VALUE_W-1:0] a_value;
   } elem_info_type;

endpackage

### hw/rtl/srk_req_if.sv
interface srk_req_if import srk_pkg::*; ();

   logic         valid;
   logic         ready;
   req_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);

endinterface

### hw/rtl/srk_rsp_if.sv
interface srk_rsp_if import srk_pkg::*; ();

   logic         valid;
   logic         ready;
   rsp_word_type word;

   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);

endinterface

### hw/rtl/srk_vec_mem.sv
module srk_vec_mem import srk_pkg::*; #(
   parameter int DEPTH  = DEFAULT_MAX_N,
   parameter int ADDR_W = $clog2(DEFAULT_MAX_N),
   parameter int DATA_W = VEC_W
) (
   input  logic              clock,
   input  logic              wr_enable,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_enable,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_enable) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_enable) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

### hw/rtl/srk_ctrl.sv
module srk_ctrl import srk_pkg::*; #(
   parameter int MAX_N  = DEFAULT_MAX_N,
   parameter int ADDR_W = $clog2(DEFAULT_MAX_N),
   parameter int CNT_W  = $clog2(DEFAULT_MAX_N + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   input  req_word_type      req_word,
   input  logic              stage_enable,
   output logic              wr_enable,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [VEC_W-1:0]  wr_data,
   output logic [ADDR_W-1:0] rd_addr_row,
   output logic [ADDR_W-1:0] rd_addr_col,
   output logic              info_valid,
   output elem_info_type     info
);

   logic [CNT_W-1:0]  load_ff, load_in;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;
   logic              info_valid_ff, info_valid_in;
   elem_info_type     info_ff, info_in;

   logic [CNT_W-1:0]  order;
   logic              accept;
   logic              row_wrap;
   logic              col_wrap;

   // Effective order: a size of zero acts as one, and sizes above the store depth clamp.
   always_comb begin
      if (int'(cfg.matrix_size) > MAX_N) begin
         order = CNT_W'(MAX_N);
      end else if (cfg.matrix_size == '0) begin
         order = CNT_W'(1);
      end else begin
         order = CNT_W'(cfg.matrix_size);
      end
   end

   assign accept   = req_valid && stage_enable;
   assign row_wrap = (CNT_W'(row_ff) + CNT_W'(1)) >= order;
   assign col_wrap = (CNT_W'(col_ff) + CNT_W'(1)) >= order;

   assign wr_enable   = accept && (req_word.mode == MODE_LOAD) && (load_ff < order);
   assign wr_addr     = load_ff[ADDR_W-1:0];
   assign wr_data     = {req_word.x_value, req_word.y_value};
   assign rd_addr_row = row_ff;
   assign rd_addr_col = col_ff;

   always_comb begin
      load_in = load_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (wr_enable) begin
         load_in = load_ff + CNT_W'(1);
      end
      if (accept && (req_word.mode == MODE_MATRIX)) begin
         if (row_wrap) begin
            row_in = '0;
            if (col_wrap) begin
               // The final element closes the problem and rearms the vector loads.
               col_in  = '0;
               load_in = '0;
            end else begin
               col_in = col_ff + ADDR_W'(1);
            end
         end else begin
            row_in = row_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      info_valid_in       = accept && (req_word.mode == MODE_MATRIX);
      info_in.in_triangle = cfg.upper_fill ? (row_ff <= col_ff) : (col_ff <= row_ff);
      info_in.last        = row_wrap && col_wrap;
      info_in.row         = INDEX_W'(row_ff);
      info_in.col         = INDEX_W'(col_ff);
      info_in.a_value     = req_word.a_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff       <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         info_valid_ff <= 1'b0;
      end else begin
         load_ff <= load_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
         if (stage_enable) begin
            info_valid_ff <= info_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_enable) begin
         info_ff <= info_in;
      end
   end

   assign info_valid = info_valid_ff;
   assign info       = info_ff;

endmodule

### hw/rtl/srk_datapath.sv
module srk_datapath import srk_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic signed [VALUE_W-1:0] alpha,
   input  logic                      in_valid,
   input  elem_info_type             in_info,
   input  logic [VEC_W-1:0]          row_word,
   input  logic [VEC_W-1:0]          col_word,
   input  logic                      rsp_ready,
   output logic                      stage_enable,
   output logic                      rsp_valid,
   output rsp_word_type              rsp_word
);

   logic signed [VALUE_W-1:0] x_row, y_row, x_col, y_col;

   logic mul_en, sum_en, scale_en, trim_en, out_en;

   logic          mul_valid_ff, sum_valid_ff, scale_valid_ff, trim_valid_ff, rsp_valid_ff;
   elem_info_type mul_info_ff, sum_info_ff, scale_info_ff, trim_info_ff;

   logic signed [63:0] p1_ff, p1_in, p2_ff, p2_in;
   logic        [64:0] pair_sum;
   logic signed [48:0] s_ff, s_in;
   logic signed [32:0] s_hi;
   logic signed [16:0] s_lo;
   logic signed [64:0] m_hi_ff, m_hi_in;
   logic signed [48:0] m_lo_ff, m_lo_in;
   logic signed [65:0] t_ff, t_in;
   logic        [66:0] total;
   logic signed [VALUE_W-1:0] sat_value;
   rsp_word_type rsp_word_ff, rsp_word_in;

   assign x_row = row_word[VEC_W-1:VALUE_W];
   assign y_row = row_word[VALUE_W-1:0];
   assign x_col = col_word[VEC_W-1:VALUE_W];
   assign y_col = col_word[VALUE_W-1:0];

   // A stage takes a new word when it is empty or its own word moves on.
   assign out_en       = !rsp_valid_ff || rsp_ready;
   assign trim_en      = !trim_valid_ff || out_en;
   assign scale_en     = !scale_valid_ff || trim_en;
   assign sum_en       = !sum_valid_ff || scale_en;
   assign mul_en       = !mul_valid_ff || sum_en;
   assign stage_enable = !in_valid || mul_en;

   assign p1_in = x_row * y_col;
   assign p2_in = y_row * x_col;

   // Exact sum of both products, then floor by 2^16 by dropping the low bits.
   assign pair_sum = {p1_ff[63], p1_ff} + {p2_ff[63], p2_ff};
   assign s_in     = pair_sum[64:16];

   // alpha*s is split at bit 16 so that each multiplier stays near 32 by 32.
   assign s_hi    = s_ff[48:16];
   assign s_lo    = {1'b0, s_ff[15:0]};
   assign m_hi_in = alpha * s_hi;
   assign m_lo_in = alpha * s_lo;

   assign t_in = {m_hi_ff[64], m_hi_ff} + {{33{m_lo_ff[48]}}, m_lo_ff[48:16]};

   assign total = {{35{trim_info_ff.a_value[31]}}, trim_info_ff.a_value} + {t_ff[65], t_ff};

   always_comb begin
      if (total[66:31] == '0 || total[66:31] == '1) begin
         sat_value = total[31:0];
      end else if (total[66]) begin
         sat_value = {1'b1, {(VALUE_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(VALUE_W-1){1'b1}}};
      end
   end

   always_comb begin
      rsp_word_in.updated_value = trim_info_ff.in_triangle ? sat_value : trim_info_ff.a_value;
      rsp_word_in.row_index     = trim_info_ff.row;
      rsp_word_in.col_index     = trim_info_ff.col;
      rsp_word_in.last_element  = trim_info_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff   <= 1'b0;
         sum_valid_ff   <= 1'b0;
         scale_valid_ff <= 1'b0;
         trim_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (mul_en) begin
            mul_valid_ff <= in_valid;
         end
         if (sum_en) begin
            sum_valid_ff <= mul_valid_ff;
         end
         if (scale_en) begin
            scale_valid_ff <= sum_valid_ff;
         end
         if (trim_en) begin
            trim_valid_ff <= scale_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= trim_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         p1_ff       <= p1_in;
         p2_ff       <= p2_in;
         mul_info_ff <= in_info;
      end
      if (sum_en) begin
         s_ff        <= s_in;
         sum_info_ff <= mul_info_ff;
      end
      if (scale_en) begin
         m_hi_ff       <= m_hi_in;
         m_lo_ff       <= m_lo_in;
         scale_info_ff <= sum_info_ff;
      end
      if (trim_en) begin
         t_ff         <= t_in;
         trim_info_ff <= scale_info_ff;
      end
      if (out_en) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

### hw/rtl/symmetric_rank2_update.sv
// Symmetric rank-2 update on one triangle of an n-by-n Q16.16 matrix. Load words (mode 0)
// fill the x and y vectors in order, and loads past the matrix order are dropped. Matrix
// words (mode 1) arrive in column-major order and each returns one response word with the
// element, its row and column and a last flag. The block takes one word per clock while the
// response side does not stall; a matrix word reaches the response port through registered
// steps in turn: the vector memory read, the two vector products, their sum, the two alpha
// multiplies, the final scaling add and the saturating add into the output register. The
// vector memory holds MAX_N entries and needs no initialization; entries must be loaded
// before they are used.
module symmetric_rank2_update import srk_pkg::*; #(
   parameter int MAX_N = DEFAULT_MAX_N
) (
   input  logic                   clock,
   input  logic                   reset,
   srk_req_if.sink                req_port,
   srk_rsp_if.source              rsp_port,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_N);
   localparam int CNT_W  = $clog2(MAX_N + 1);

   cfg_type cfg_ff, cfg_in;

   logic              stage_enable;
   logic              wr_enable;
   logic [ADDR_W-1:0] wr_addr;
   logic [VEC_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr_row;
   logic [ADDR_W-1:0] rd_addr_col;
   logic [VEC_W-1:0]  row_word;
   logic [VEC_W-1:0]  col_word;
   logic              info_valid;
   elem_info_type     info;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MATRIX_SIZE: cfg_in.matrix_size = csr_write_data[SIZE_W-1:0];
            CSR_UPPER_FILL:  cfg_in.upper_fill  = csr_write_data[0];
            CSR_ALPHA_SCALE: cfg_in.alpha_scale = csr_write_data[VALUE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix_size <= RESET_MATRIX_SIZE;
         cfg_ff.upper_fill  <= RESET_UPPER_FILL;
         cfg_ff.alpha_scale <= RESET_ALPHA_SCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_port.ready = stage_enable;

   srk_ctrl #(
      .MAX_N  (MAX_N),
      .ADDR_W (ADDR_W),
      .CNT_W  (CNT_W)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_valid    (req_port.valid),
      .req_word     (req_port.word),
      .stage_enable (stage_enable),
      .wr_enable    (wr_enable),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_addr_row  (rd_addr_row),
      .rd_addr_col  (rd_addr_col),
      .info_valid   (info_valid),
      .info         (info)
   );

   // Each entry holds one {x, y} pair, read once at the row and once at the column.
   srk_vec_mem #(
      .DEPTH  (MAX_N),
      .ADDR_W (ADDR_W),
      .DATA_W (VEC_W)
   ) u_vec_mem (
      .clock     (clock),
      .wr_enable (wr_enable),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_enable (stage_enable),
      .rd_addr_a (rd_addr_row),
      .rd_addr_b (rd_addr_col),
      .rd_data_a (row_word),
      .rd_data_b (col_word)
   );

   srk_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .alpha        (cfg_ff.alpha_scale),
      .in_valid     (info_valid),
      .in_info      (info),
      .row_word     (row_word),
      .col_word     (col_word),
      .rsp_ready    (rsp_port.ready),
      .stage_enable (stage_enable),
      .rsp_valid    (rsp_port.valid),
      .rsp_word     (rsp_port.word)
   );

endmodule
